// ----- design/nca_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_pkg
// Shared constants, command codes and types of the nearest-center assignment.
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam int DEF_MAX_CENTERS = 64;
    localparam int DEF_MAX_DIMS    = 16;
    localparam int DEF_COORD_BITS  = 16;

    localparam int CMD_BITS       = 2;
    localparam int CENTER_ID_BITS = 6;
    localparam int SLOT_BITS      = 6;
    localparam int SLOT_COUNT     = 64;
    localparam int DIM_ID_BITS    = 4;
    localparam int COORD_IN_BITS  = 16;
    localparam int PIDX_BITS      = 16;
    localparam int DIST_BITS      = 36;

    localparam int S_TDATA_BITS = 48;
    localparam int M_TDATA_BITS = 64;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 7;
    localparam int CAND_CNT_BITS = 7;
    localparam int DIM_CNT_BITS  = 5;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CAND_COUNT = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_COUNT  = 2'd1;

    localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_CENTER = 2'd0,
        CMD_SLOT   = 2'd1,
        CMD_POINT  = 2'd2
    } cmd_t;

    typedef struct packed {
        logic rd_en;
        logic acc_clear;
    } dist_ctl_t;

    typedef struct packed {
        logic [DIST_BITS-1:0]      distance;
        logic [CENTER_ID_BITS-1:0] center;
        logic [PIDX_BITS-1:0]      point_index;
    } result_t;

endpackage

// ----- design/nearest_center_assignment.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_center_assignment
// K-means assignment step: nearest of the listed candidate centers per point.
//
//   channel | dir | handshake          | payload
//   s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser (command), s_tlast
//   m_      | out | m_tvalid/m_tready  | m_tdata
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Load commands and non-final point coordinates are written into the stores.
// A final point coordinate starts the search: one shared subtract/square/
// accumulate pipeline walks every coordinate of every candidate, one
// center-store read per cycle, each candidate framed by table read and drain.
// s_tready is low from the final coordinate until the result enters the
// output register; a stalled m_ side holds the search in its last step.
// Reset clears configuration to 1 and 1; stores hold no reset value.
// ----------------------------------------------------------------------------
module nearest_center_assignment #(
    parameter int MAX_CENTERS = nca_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = nca_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS  = nca_pkg::DEF_COORD_BITS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // center_index, slot_index, dim_index, coord_value, point_index
    input  logic [nca_pkg::S_TDATA_BITS-1:0]   s_tdata,
    // command
    input  logic [nca_pkg::CMD_BITS-1:0]       s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_point_index, assigned_center, best_distance, zero pad
    output logic [nca_pkg::M_TDATA_BITS-1:0]   m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nca_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [nca_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int EffBits = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int DimBits = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam logic [nca_pkg::CAND_CNT_BITS-1:0] SlotsMax =
        nca_pkg::CAND_CNT_BITS'(nca_pkg::SLOT_COUNT);
    localparam logic [nca_pkg::CAND_CNT_BITS-1:0] DimsMax =
        nca_pkg::CAND_CNT_BITS'(MAX_DIMS);

    logic [nca_pkg::CENTER_ID_BITS-1:0] in_center;
    logic [nca_pkg::SLOT_BITS-1:0]      in_slot;
    logic [nca_pkg::DIM_ID_BITS-1:0]    in_dim;
    logic [nca_pkg::COORD_IN_BITS-1:0]  in_coord;
    logic [nca_pkg::PIDX_BITS-1:0]      in_pidx;

    assign in_center = s_tdata[5:0];
    assign in_slot   = s_tdata[11:6];
    assign in_dim    = s_tdata[15:12];
    assign in_coord  = s_tdata[31:16];
    assign in_pidx   = s_tdata[47:32];

    logic s_xfer;
    logic is_center, is_slot, is_point, start;

    assign s_xfer    = s_tvalid && s_tready;
    assign is_center = s_xfer && (s_tuser == nca_pkg::CMD_CENTER);
    assign is_slot   = s_xfer && (s_tuser == nca_pkg::CMD_SLOT);
    assign is_point  = s_xfer && (s_tuser == nca_pkg::CMD_POINT);
    assign start     = is_point && s_tlast;

    // configuration
    logic [nca_pkg::CAND_CNT_BITS-1:0] cand_count_reg;
    logic [nca_pkg::DIM_CNT_BITS-1:0]  dim_count_reg;
    logic [nca_pkg::CAND_CNT_BITS-1:0] dim_count_ext;
    logic [nca_pkg::SLOT_BITS-1:0]     slot_last;
    logic [DimBits-1:0]                dims_last;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_count_reg <= nca_pkg::CAND_CNT_BITS'(1);
            dim_count_reg  <= nca_pkg::DIM_CNT_BITS'(1);
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == nca_pkg::CFG_CAND_COUNT) begin
                cand_count_reg <= cfg_data;
            end else if (cfg_index == nca_pkg::CFG_DIM_COUNT) begin
                dim_count_reg <= cfg_data[nca_pkg::DIM_CNT_BITS-1:0];
            end
        end
    end

    always_comb begin
        dim_count_ext = nca_pkg::CAND_CNT_BITS'(dim_count_reg);
        if (cand_count_reg == '0) begin
            slot_last = '0;
        end else if (cand_count_reg > SlotsMax) begin
            slot_last = '1;
        end else begin
            slot_last = nca_pkg::SLOT_BITS'(cand_count_reg - 1'b1);
        end
        if (dim_count_ext == '0) begin
            dims_last = '0;
        end else if (dim_count_ext > DimsMax) begin
            dims_last = DimBits'(DimsMax - 1'b1);
        end else begin
            dims_last = DimBits'(dim_count_ext - 1'b1);
        end
    end

    // datapath
    logic                               idle;
    logic                               cand_rd_en;
    logic [nca_pkg::SLOT_BITS-1:0]      cand_rd_slot;
    logic [nca_pkg::CENTER_ID_BITS-1:0] cand_data;
    nca_pkg::dist_ctl_t                 dist_ctl;
    logic [DimBits-1:0]                 rd_dim;
    logic signed [EffBits-1:0]          center_data;
    logic signed [EffBits-1:0]          point_data;
    logic [nca_pkg::DIST_BITS-1:0]      acc;
    logic                               dist_busy;
    logic                               res_valid;
    logic                               res_ready;
    nca_pkg::result_t                   result;

    nca_store #(
        .MAX_CENTERS (MAX_CENTERS),
        .MAX_DIMS    (MAX_DIMS),
        .COORD_BITS  (COORD_BITS)
    ) u_store (
        .aclk           (aclk),
        .wr_center_en   (is_center),
        .wr_slot_en     (is_slot),
        .wr_point_en    (is_point),
        .in_center      (in_center),
        .in_slot        (in_slot),
        .in_dim         (in_dim),
        .in_coord       (in_coord),
        .cand_rd_en     (cand_rd_en),
        .cand_rd_slot   (cand_rd_slot),
        .cand_rd_data   (cand_data),
        .dist_ctl       (dist_ctl),
        .rd_dim         (rd_dim),
        .center_rd_data (center_data),
        .point_rd_data  (point_data)
    );

    nca_dist_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_dist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .dist_ctl    (dist_ctl),
        .point_data  (point_data),
        .center_data (center_data),
        .acc         (acc),
        .busy        (dist_busy)
    );

    nca_search_ctrl #(
        .MAX_DIMS (MAX_DIMS)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (start),
        .start_pidx   (in_pidx),
        .slot_last    (slot_last),
        .dims_last    (dims_last),
        .cand_data    (cand_data),
        .acc          (acc),
        .busy         (dist_busy),
        .res_ready    (res_ready),
        .idle         (idle),
        .cand_rd_en   (cand_rd_en),
        .cand_rd_slot (cand_rd_slot),
        .dist_ctl     (dist_ctl),
        .rd_dim       (rd_dim),
        .res_valid    (res_valid),
        .result       (result)
    );

    assign s_tready = idle;

    // output register
    logic             m_tvalid_reg;
    nca_pkg::result_t m_result_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_result_reg <= result;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, m_result_reg.distance, m_result_reg.center,
                       m_result_reg.point_index};

    // checks
    a_busy_after_start: assert property (@(posedge aclk) disable iff (!aresetn)
        start |=> !s_tready)
        else $error("input accepted while a search runs");

    a_result_from_search: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a search");

    a_idle_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !dist_busy)
        else $error("distance pipeline busy while idle");

endmodule

// ----- design/nca_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_store
// Center store, candidate table and point buffer with registered reads.
// ----------------------------------------------------------------------------
module nca_store #(
    parameter int MAX_CENTERS = nca_pkg::DEF_MAX_CENTERS,
    parameter int MAX_DIMS    = nca_pkg::DEF_MAX_DIMS,
    parameter int COORD_BITS  = nca_pkg::DEF_COORD_BITS,
    localparam int EffBits    = (COORD_BITS < 16) ? COORD_BITS : 16,
    localparam int DimBits    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                                aclk,
    input  logic                                wr_center_en,
    input  logic                                wr_slot_en,
    input  logic                                wr_point_en,
    input  logic [nca_pkg::CENTER_ID_BITS-1:0]  in_center,
    input  logic [nca_pkg::SLOT_BITS-1:0]       in_slot,
    input  logic [nca_pkg::DIM_ID_BITS-1:0]     in_dim,
    input  logic [nca_pkg::COORD_IN_BITS-1:0]   in_coord,
    input  logic                                cand_rd_en,
    input  logic [nca_pkg::SLOT_BITS-1:0]       cand_rd_slot,
    output logic [nca_pkg::CENTER_ID_BITS-1:0]  cand_rd_data,
    input  nca_pkg::dist_ctl_t                  dist_ctl,
    input  logic [DimBits-1:0]                  rd_dim,
    output logic signed [EffBits-1:0]           center_rd_data,
    output logic signed [EffBits-1:0]           point_rd_data
);

    localparam int CenterBits = $clog2(MAX_CENTERS);
    localparam int AddrBits   = CenterBits + DimBits;
    localparam int StoreDepth = MAX_CENTERS << DimBits;
    localparam int CenterIds  = 1 << nca_pkg::CENTER_ID_BITS;
    localparam int DimIds     = 1 << nca_pkg::DIM_ID_BITS;

    logic [CenterBits-1:0] center_wrap [CenterIds];
    logic [DimBits-1:0]    dim_wrap    [DimIds];

    for (genvar g = 0; g < CenterIds; g++) begin : g_cwrap
        assign center_wrap[g] = CenterBits'(g % MAX_CENTERS);
    end
    for (genvar g = 0; g < DimIds; g++) begin : g_dwrap
        assign dim_wrap[g] = DimBits'(g % MAX_DIMS);
    end

    logic signed [EffBits-1:0]          center_mem [StoreDepth];
    logic [nca_pkg::CENTER_ID_BITS-1:0] cand_mem   [nca_pkg::SLOT_COUNT];
    logic signed [EffBits-1:0]          point_mem  [MAX_DIMS];

    logic signed [EffBits-1:0] coord_trim;
    logic [AddrBits-1:0]       wr_addr;
    logic [AddrBits-1:0]       rd_addr;

    assign coord_trim = in_coord[EffBits-1:0];
    assign wr_addr    = {center_wrap[in_center], dim_wrap[in_dim]};
    assign rd_addr    = {center_wrap[cand_rd_data], rd_dim};

    always_ff @(posedge aclk) begin
        if (wr_center_en) begin
            center_mem[wr_addr] <= coord_trim;
        end
        if (wr_slot_en) begin
            cand_mem[in_slot] <= in_center;
        end
        if (wr_point_en) begin
            point_mem[dim_wrap[in_dim]] <= coord_trim;
        end
        if (cand_rd_en) begin
            cand_rd_data <= cand_mem[cand_rd_slot];
        end
        if (dist_ctl.rd_en) begin
            center_rd_data <= center_mem[rd_addr];
            point_rd_data  <= point_mem[rd_dim];
        end
    end

endmodule

// ----- design/nca_dist_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_dist_unit
// Shared subtract, square and saturating accumulate pipeline.
// ----------------------------------------------------------------------------
module nca_dist_unit #(
    parameter int COORD_BITS = nca_pkg::DEF_COORD_BITS,
    localparam int EffBits   = (COORD_BITS < 16) ? COORD_BITS : 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  nca_pkg::dist_ctl_t             dist_ctl,
    input  logic signed [EffBits-1:0]      point_data,
    input  logic signed [EffBits-1:0]      center_data,
    output logic [nca_pkg::DIST_BITS-1:0]  acc,
    output logic                           busy
);

    localparam int MagBits  = EffBits + 1;
    localparam int ProdBits = 2 * MagBits;
    localparam int SumBits  = nca_pkg::DIST_BITS + 1;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [MagBits-1:0]            mag_reg;
    logic [ProdBits-1:0]           prod_reg;
    logic [nca_pkg::DIST_BITS-1:0] acc_reg;

    logic signed [MagBits-1:0]     diff;
    logic [MagBits-1:0]            mag_next;
    logic [SumBits-1:0]            sum;
    logic [nca_pkg::DIST_BITS-1:0] acc_next;

    always_comb begin
        diff     = MagBits'(point_data) - MagBits'(center_data);
        mag_next = diff[MagBits-1] ? MagBits'(-diff) : MagBits'(diff);
        sum      = {1'b0, acc_reg} + SumBits'(prod_reg);
        acc_next = sum[nca_pkg::DIST_BITS] ? nca_pkg::DIST_MAX
                                           : sum[nca_pkg::DIST_BITS-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            acc_reg <= '0;
        end else begin
            v1_reg <= dist_ctl.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (dist_ctl.acc_clear) begin
                acc_reg <= '0;
            end else if (v3_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            mag_reg <= mag_next;
        end
        if (v2_reg) begin
            prod_reg <= mag_reg * mag_reg;
        end
    end

    assign acc  = acc_reg;
    // terms not yet in the product register
    assign busy = v1_reg | v2_reg;

endmodule

// ----- design/nca_search_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nca_search_ctrl
// Sequencer over candidate slots and coordinates; keeps the running minimum.
// ----------------------------------------------------------------------------
module nca_search_ctrl #(
    parameter int MAX_DIMS  = nca_pkg::DEF_MAX_DIMS,
    localparam int DimBits  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [nca_pkg::PIDX_BITS-1:0]       start_pidx,
    input  logic [nca_pkg::SLOT_BITS-1:0]       slot_last,
    input  logic [DimBits-1:0]                  dims_last,
    input  logic [nca_pkg::CENTER_ID_BITS-1:0]  cand_data,
    input  logic [nca_pkg::DIST_BITS-1:0]       acc,
    input  logic                                busy,
    input  logic                                res_ready,
    output logic                                idle,
    output logic                                cand_rd_en,
    output logic [nca_pkg::SLOT_BITS-1:0]       cand_rd_slot,
    output nca_pkg::dist_ctl_t                  dist_ctl,
    output logic [DimBits-1:0]                  rd_dim,
    output logic                                res_valid,
    output nca_pkg::result_t                    result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CAND,
        ST_DIMS,
        ST_DRAIN,
        ST_CMP,
        ST_OUT
    } state_t;

    state_t                             state_reg, state_next;
    logic [nca_pkg::SLOT_BITS-1:0]      slot_reg, slot_next;
    logic [DimBits-1:0]                 dim_reg, dim_next;
    logic [nca_pkg::DIST_BITS-1:0]      best_reg, best_next;
    logic [nca_pkg::CENTER_ID_BITS-1:0] center_reg, center_next;
    logic [nca_pkg::PIDX_BITS-1:0]      pidx_reg, pidx_next;

    always_comb begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        dim_next    = dim_reg;
        best_next   = best_reg;
        center_next = center_reg;
        pidx_next   = pidx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    pidx_next  = start_pidx;
                    slot_next  = '0;
                    state_next = ST_CAND;
                end
            end
            ST_CAND: begin
                dim_next   = '0;
                state_next = ST_DIMS;
            end
            ST_DIMS: begin
                if (dim_reg == dims_last) begin
                    state_next = ST_DRAIN;
                end else begin
                    dim_next = dim_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (!busy) begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                // strict compare: earlier slot keeps a tie
                if ((slot_reg == '0) || (acc < best_reg)) begin
                    best_next   = acc;
                    center_next = cand_data;
                end
                if (slot_reg == slot_last) begin
                    state_next = ST_OUT;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    state_next = ST_CAND;
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        slot_reg   <= slot_next;
        dim_reg    <= dim_next;
        best_reg   <= best_next;
        center_reg <= center_next;
        pidx_reg   <= pidx_next;
    end

    assign idle               = (state_reg == ST_IDLE);
    assign cand_rd_en         = (state_reg == ST_CAND);
    assign cand_rd_slot       = slot_reg;
    assign dist_ctl.acc_clear = (state_reg == ST_CAND);
    assign dist_ctl.rd_en     = (state_reg == ST_DIMS);
    assign rd_dim             = dim_reg;
    assign res_valid          = (state_reg == ST_OUT);
    assign result.point_index = pidx_reg;
    assign result.center      = center_reg;
    assign result.distance    = best_reg;

endmodule
